/* sv/sha1_pkg.sv */
// Shared types, constants and round helpers for the SHA-1 hash engine.
// Used by the controller, the datapath and the top level; no dependencies.
package sha1_pkg;

  localparam int WordW       = 32;
  localparam int ByteW       = 8;
  localparam int CntW        = 6;
  localparam int LenW        = 64;
  localparam int RndW        = 7;
  localparam int IdxW        = 3;
  localparam int AccW        = 24;
  localparam int NumRounds   = 80;
  localparam int PhaseLen    = 20;
  localparam int DigestWords = 5;
  localparam int WinDepth    = 16;

  localparam logic [RndW-1:0]  LastRound   = RndW'(NumRounds - 1);
  localparam logic [IdxW-1:0]  LastWordIdx = IdxW'(DigestWords - 1);
  localparam logic [CntW-1:0]  LastByteCnt = CntW'(63);
  localparam logic [CntW-1:0]  LenStartCnt = CntW'(56);
  localparam logic [LenW-1:0]  BitsPerByte = LenW'(8);
  localparam logic [ByteW-1:0] PadMark     = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic            put_byte;
    byte_sel_t       byte_sel;
    logic            add_len;
    logic            start_block;
    logic            round_en;
    logic [RndW-1:0] round_idx;
    logic            add_hash;
    logic            clear_msg;
    logic [IdxW-1:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic last_byte;
    logic len_start;
  } dp_stat_t;

  function automatic logic [WordW-1:0] hash_init(input logic [IdxW-1:0] idx);
    logic [WordW-1:0] v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      default: v = 32'hC3D2E1F0;
    endcase
    return v;
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [RndW-1:0] t);
    logic [WordW-1:0] k;
    if (t < RndW'(PhaseLen))          k = 32'h5A827999;
    else if (t < RndW'(2 * PhaseLen)) k = 32'h6ED9EBA1;
    else if (t < RndW'(3 * PhaseLen)) k = 32'h8F1BBCDC;
    else                              k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [RndW-1:0]  t,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    if (t < RndW'(PhaseLen))
      f = (b & c) | (~b & d);
    else if (t < RndW'(2 * PhaseLen) || t >= RndW'(3 * PhaseLen))
      f = b ^ c ^ d;
    else
      f = (b & c) | (b & d) | (c & d);
    return f;
  endfunction

endpackage

/* sv/sha1_dp.sv */
// Datapath of the SHA-1 hash engine: byte packing, schedule shift line,
// round logic, chaining words and length counter. Depends on sha1_pkg.
module sha1_dp
  import sha1_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [ByteW-1:0]  data_byte,
  output dp_stat_t          stat,
  output logic [WordW-1:0]  digest_word
);

  logic [WordW-1:0] hash_r [DigestWords];
  logic [WordW-1:0] work_r [DigestWords];
  logic [WordW-1:0] win_r  [WinDepth];
  logic [AccW-1:0]  acc_r;
  logic [CntW-1:0]  cnt_r;
  logic [LenW-1:0]  len_r;

  logic [ByteW-1:0] byte_in;
  logic [CntW-1:0]  len_sh;
  logic [WordW-1:0] f_val;
  logic [WordW-1:0] tmp_val;
  logic [WordW-1:0] w_mix;

  assign len_sh = {~cnt_r[2:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      BSEL_DATA: byte_in = data_byte;
      BSEL_MARK: byte_in = PadMark;
      BSEL_ZERO: byte_in = '0;
      default:   byte_in = len_r[len_sh +: ByteW];
    endcase
  end

  assign f_val   = round_f(cmd.round_idx, work_r[1], work_r[2], work_r[3]);
  assign tmp_val = {work_r[0][26:0], work_r[0][31:27]} + f_val + work_r[4]
                 + round_k(cmd.round_idx) + win_r[0];
  assign w_mix   = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];

  assign stat.last_byte = (cnt_r == LastByteCnt);
  assign stat.len_start = (cnt_r == LenStartCnt);
  assign digest_word    = hash_r[cmd.out_idx];

  // Chaining words, byte count and bit length carry reset values.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_msg) begin
      for (int i = 0; i < DigestWords; i++) hash_r[i] <= hash_init(IdxW'(i));
      cnt_r <= '0;
      len_r <= '0;
    end else begin
      if (cmd.add_hash) begin
        for (int i = 0; i < DigestWords; i++) hash_r[i] <= hash_r[i] + work_r[i];
      end
      if (cmd.put_byte) cnt_r <= cnt_r + CntW'(1);
      if (cmd.add_len)  len_r <= len_r + BitsPerByte;
    end
  end

  // Byte packing, schedule window and working words.
  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      case (cnt_r[1:0])
        2'd0:    acc_r[23:16] <= byte_in;
        2'd1:    acc_r[15:8]  <= byte_in;
        2'd2:    acc_r[7:0]   <= byte_in;
        default: begin
          for (int i = 0; i < WinDepth - 1; i++) win_r[i] <= win_r[i+1];
          win_r[WinDepth-1] <= {acc_r, byte_in};
        end
      endcase
    end else if (cmd.round_en) begin
      for (int i = 0; i < WinDepth - 1; i++) win_r[i] <= win_r[i+1];
      win_r[WinDepth-1] <= {w_mix[30:0], w_mix[31]};
    end
    if (cmd.start_block) begin
      for (int i = 0; i < DigestWords; i++) work_r[i] <= hash_r[i];
    end else if (cmd.round_en) begin
      work_r[0] <= tmp_val;
      work_r[1] <= work_r[0];
      work_r[2] <= {work_r[1][1:0], work_r[1][31:2]};
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3];
    end
  end

endmodule

/* sv/sha1_ctrl.sv */
// Controller of the SHA-1 hash engine: sequences byte intake, the rounds,
// the final padding and the digest beats. Depends on sha1_pkg.
module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_byte_valid,
  input  logic            in_message_end,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            last_word,
  input  dp_stat_t        stat,
  output dp_cmd_t         cmd
);

  state_t          state_r, state_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic [IdxW-1:0] oidx_r, oidx_nxt;
  logic            end_pend_r, end_pend_nxt;
  logic            mark_r, mark_nxt;
  logic            lenph_r, lenph_nxt;
  logic            done_r, done_nxt;
  logic            in_take;
  logic            len_now;

  assign in_take = in_valid && (state_r == ST_IDLE);
  assign len_now = !mark_r && (lenph_r || stat.len_start);

  // Next state.
  always_comb begin
    state_nxt    = state_r;
    rnd_nxt      = rnd_r;
    oidx_nxt     = oidx_r;
    end_pend_nxt = end_pend_r;
    mark_nxt     = mark_r;
    lenph_nxt    = lenph_r;
    done_nxt     = done_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          end_pend_nxt = in_message_end;
          mark_nxt     = in_message_end;
          if (in_byte_valid && stat.last_byte) state_nxt = ST_ROUND;
          else if (in_message_end)             state_nxt = ST_PAD;
        end
      end
      ST_ROUND: begin
        if (rnd_r == LastRound) begin
          rnd_nxt   = '0;
          state_nxt = ST_ADD;
        end else begin
          rnd_nxt = rnd_r + RndW'(1);
        end
      end
      ST_ADD: begin
        if (done_r)          state_nxt = ST_OUT;
        else if (end_pend_r) state_nxt = ST_PAD;
        else                 state_nxt = ST_IDLE;
      end
      ST_PAD: begin
        mark_nxt = 1'b0;
        if (len_now) lenph_nxt = 1'b1;
        if (stat.last_byte) begin
          state_nxt = ST_ROUND;
          done_nxt  = lenph_r;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          if (oidx_r == LastWordIdx) begin
            oidx_nxt     = '0;
            state_nxt    = ST_IDLE;
            end_pend_nxt = 1'b0;
            mark_nxt     = 1'b0;
            lenph_nxt    = 1'b0;
            done_nxt     = 1'b0;
          end else begin
            oidx_nxt = oidx_r + IdxW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd           = '0;
    cmd.byte_sel  = BSEL_DATA;
    cmd.round_idx = rnd_r;
    cmd.out_idx   = oidx_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    last_word     = (oidx_r == LastWordIdx);
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_take && in_byte_valid) begin
          cmd.put_byte    = 1'b1;
          cmd.add_len     = 1'b1;
          cmd.start_block = stat.last_byte;
        end
      end
      ST_ROUND: cmd.round_en = 1'b1;
      ST_ADD:   cmd.add_hash = 1'b1;
      ST_PAD: begin
        cmd.put_byte    = 1'b1;
        cmd.start_block = stat.last_byte;
        if (mark_r)       cmd.byte_sel = BSEL_MARK;
        else if (len_now) cmd.byte_sel = BSEL_LEN;
        else              cmd.byte_sel = BSEL_ZERO;
      end
      ST_OUT: begin
        out_valid     = 1'b1;
        cmd.clear_msg = out_ready && (oidx_r == LastWordIdx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rnd_r      <= '0;
      oidx_r     <= '0;
      end_pend_r <= 1'b0;
      mark_r     <= 1'b0;
      lenph_r    <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rnd_r      <= rnd_nxt;
      oidx_r     <= oidx_nxt;
      end_pend_r <= end_pend_nxt;
      mark_r     <= mark_nxt;
      lenph_r    <= lenph_nxt;
      done_r     <= done_nxt;
    end
  end

endmodule

/* sv/sha1_hash_engine_unit.sv */
// Top level of the SHA-1 hash engine: controller plus datapath.
// Depends on sha1_pkg, sha1_ctrl and sha1_dp.

// SHA-1 over a byte stream. Each input beat carries one message byte with a
// byte valid mark and a message end mark; a beat whose byte is not valid and
// that is not an end beat is dropped. Every 64th message byte starts the
// compression, which runs one round per cycle through all NumRounds rounds
// and then folds the block into the chaining words. The end beat triggers
// padding, which the engine writes one byte per cycle through the same byte
// path (0x80, zeros, then the 64-bit big-endian bit length), followed by one or
// two more compressions. The digest then leaves as five beats, H0 first, with
// last_word set on the fifth; after that beat the engine restarts with the
// initial chaining values for a new message. Input beats are taken only while
// the engine waits for message bytes, never during rounds, padding or output.
module sha1_hash_engine_unit
  import sha1_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_data_byte,
  input  logic             in_byte_valid,
  input  logic             in_message_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_digest_word,
  output logic [IdxW-1:0]  out_word_num,
  output logic             out_last_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller owns all sequencing; the datapath only follows commands.
  sha1_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte_valid  (in_byte_valid),
    .in_message_end (in_message_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .last_word      (out_last_word),
    .stat           (stat),
    .cmd            (cmd)
  );

  sha1_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .data_byte   (in_data_byte),
    .stat        (stat),
    .digest_word (out_digest_word)
  );

  // The digest word number is the controller's output beat counter.
  assign out_word_num = cmd.out_idx;

endmodule
